// ===== design/hourly_key_counter_table_assert.svh =====
// Assertion macros for the hourly key counter table.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef HOURLY_KEY_COUNTER_TABLE_ASSERT_SVH
`define HOURLY_KEY_COUNTER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define HKC_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define HKC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define HKC_ASSERT(label, expr, msg)
`define HKC_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ===== design/hkc_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// hourly key counter table. No dependencies.
package hkc_pkg;

  localparam int MAX_ENTRIES  = 256;
  localparam int MODULE_COUNT = 8;

  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FILL_W  = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W   = 31;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 56;
  localparam int SPEED_W = 24;
  localparam int ENTRY_W = KEY_W + CNT_W;

  typedef struct packed {
    logic load;    // latch a new word
    logic scan;    // walk the table
    logic commit;  // update state and load the result register
  } hkc_cmd_t;

  typedef struct packed {
    logic hit;     // key found during the walk
    logic done;    // walk finished without a hit, or no walk needed
  } hkc_sts_t;

endpackage

// ===== design/hkc_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read data.
// No dependencies.
module hkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/hkc_ctrl.sv =====
// Controller for the hourly key counter table: sequences accept, table
// walk and commit, and owns the result valid flag. Uses hkc_pkg.
module hkc_ctrl import hkc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hkc_cmd_t cmd_o,
  input  hkc_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.commit = (state_q == S_UPDATE) && out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.hit || sts_i.done) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/hkc_dp.sv =====
// Datapath for the hourly key counter table: word registers, key/count
// table in RAM, fill count, speed statistics and result register.
// Uses hkc_pkg and hkc_ram.
module hkc_dp import hkc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hkc_cmd_t           cmd_i,
  output hkc_sts_t           sts_o,
  input  logic               cmd_word_i,
  input  logic [2:0]         module_id_i,
  input  logic [13:0]        year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  input  logic [4:0]         hour_i,
  input  logic               has_speed_i,
  input  logic               speed_in_range_i,
  input  logic [SPEED_W-1:0] speed_i,
  output logic               accepted_o,
  output logic [CNT_W-1:0]   key_count_o,
  output logic [8:0]         total_entries_o,
  output logic [CNT_W-1:0]   valid_samples_o,
  output logic [CNT_W-1:0]   excluded_samples_o,
  output logic [SUM_W-1:0]   speed_total_o
);

  // word registers
  logic               clr_q, mod_ok_q, has_speed_q, in_range_q;
  logic [KEY_W-1:0]   key_q;
  logic [SPEED_W-1:0] speed_q;

  // walk state
  logic [FILL_W-1:0]  scan_idx_q;
  logic [IDX_W-1:0]   cmp_idx_q, hit_idx_q;
  logic               cmp_vld_q, hit_q;
  logic [CNT_W-1:0]   hit_cnt_q;
  logic               issue, hit_now;

  // persistent state
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]   vcnt_q, vcnt_d, xcnt_q, xcnt_d;
  logic [SUM_W-1:0]   sum_q, sum_d;

  // result register
  logic               acc_q, acc_d;
  logic [CNT_W-1:0]   kcnt_q, kcnt_d;
  logic [8:0]         tot_q;
  logic [CNT_W-1:0]   vres_q, xres_q;
  logic [SUM_W-1:0]   sres_q;

  // table
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [CNT_W-1:0]   rd_cnt, new_cnt;
  logic [SUM_W:0]     sum_add;
  logic               room;

  hkc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (scan_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_key = ram_rdata[ENTRY_W-1:CNT_W];
  assign rd_cnt = ram_rdata[CNT_W-1:0];

  assign issue   = cmd_i.scan && (scan_idx_q != fill_q);
  assign hit_now = cmd_i.scan && cmp_vld_q && !clr_q && mod_ok_q && (rd_key == key_q);

  always_comb begin
    sts_o.hit  = hit_now;
    sts_o.done = cmd_i.scan &&
                 (clr_q || !mod_ok_q || (!cmp_vld_q && (scan_idx_q == fill_q)));
  end

  assign room    = (32'(fill_q) < MAX_ENTRIES);
  assign new_cnt = hit_q ? ((hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1)
                         : CNT_W'(1);
  assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(speed_q);

  always_comb begin
    fill_d    = fill_q;
    vcnt_d    = vcnt_q;
    xcnt_d    = xcnt_q;
    sum_d     = sum_q;
    acc_d     = 1'b0;
    kcnt_d    = '0;
    ram_we    = 1'b0;
    ram_waddr = hit_q ? hit_idx_q : fill_q[IDX_W-1:0];
    ram_wdata = {key_q, new_cnt};
    if (clr_q) begin
      acc_d  = 1'b1;
      fill_d = '0;
      vcnt_d = '0;
      xcnt_d = '0;
      sum_d  = '0;
    end else if (mod_ok_q && (hit_q || room)) begin
      acc_d  = 1'b1;
      kcnt_d = new_cnt;
      ram_we = cmd_i.commit;
      if (!hit_q) fill_d = fill_q + 1'b1;
      if (has_speed_q) begin
        if (in_range_q) begin
          sum_d  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          vcnt_d = (vcnt_q == '1) ? vcnt_q : vcnt_q + 1'b1;
        end else begin
          xcnt_d = (xcnt_q == '1) ? xcnt_q : xcnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      clr_q       <= cmd_word_i;
      mod_ok_q    <= (32'(module_id_i) < MODULE_COUNT);
      key_q       <= {module_id_i, year_i, month_i, day_i, hour_i};
      has_speed_q <= has_speed_i;
      in_range_q  <= speed_in_range_i;
      speed_q     <= speed_i;
    end
    if (hit_now) begin
      hit_idx_q <= cmp_idx_q;
      hit_cnt_q <= rd_cnt;
    end
    if (issue) begin
      cmp_idx_q <= scan_idx_q[IDX_W-1:0];
    end
    if (cmd_i.commit) begin
      acc_q  <= acc_d;
      kcnt_q <= kcnt_d;
      tot_q  <= 9'(fill_d);
      vres_q <= vcnt_d;
      xres_q <= xcnt_d;
      sres_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      fill_q     <= '0;
      vcnt_q     <= '0;
      xcnt_q     <= '0;
      sum_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        scan_idx_q <= '0;
        cmp_vld_q  <= 1'b0;
        hit_q      <= 1'b0;
      end else begin
        if (issue) scan_idx_q <= scan_idx_q + 1'b1;
        cmp_vld_q <= issue;
        if (hit_now) hit_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        fill_q <= fill_d;
        vcnt_q <= vcnt_d;
        xcnt_q <= xcnt_d;
        sum_q  <= sum_d;
      end
    end
  end

  assign accepted_o         = acc_q;
  assign key_count_o        = kcnt_q;
  assign total_entries_o    = tot_q;
  assign valid_samples_o    = vres_q;
  assign excluded_samples_o = xres_q;
  assign speed_total_o      = sres_q;

endmodule

// ===== design/hourly_key_counter_table.sv =====
// Hourly key counter table: counts words per (module, calendar hour) key in a
// bounded table and keeps saturating speed statistics.
// Input channel: in_valid_i / in_stall_o with one word of record or clear fields.
// Output channel: out_valid_o / out_stall_i with one result word per input word.
// Keys live in a simple dual-port RAM filled in order; a lookup walks the stored
// entries one per cycle (one read each cycle, compare on the registered data).
// A walk ends at the first hit or after the last stored entry; a clear or a
// rejected module skips the walk. The next word is taken once the result is
// registered, so a new word is not taken before the last one is through.
// A finished result sits in the output register while the next word is taken;
// a second result waits in the commit step until the receiver stops stalling.
// Reset empties the table (fill count to zero) and zeroes the statistics;
// there is no clearing pass. Uses hkc_pkg, hkc_ctrl and hkc_dp.
`include "hourly_key_counter_table_assert.svh"

module hourly_key_counter_table import hkc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [2:0]         module_id_i,
  input  logic [13:0]        year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  input  logic [4:0]         hour_i,
  input  logic               has_speed_i,
  input  logic               speed_in_range_i,
  input  logic [SPEED_W-1:0] speed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic [CNT_W-1:0]   key_count_o,
  output logic [8:0]         total_entries_o,
  output logic [CNT_W-1:0]   valid_samples_o,
  output logic [CNT_W-1:0]   excluded_samples_o,
  output logic [SUM_W-1:0]   speed_total_o
);

  hkc_cmd_t ctl_cmd;
  hkc_sts_t dp_sts;

  hkc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (ctl_cmd),
    .sts_i       (dp_sts)
  );

  hkc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (ctl_cmd),
    .sts_o              (dp_sts),
    .cmd_word_i         (cmd_i),
    .module_id_i        (module_id_i),
    .year_i             (year_i),
    .month_i            (month_i),
    .day_i              (day_i),
    .hour_i             (hour_i),
    .has_speed_i        (has_speed_i),
    .speed_in_range_i   (speed_in_range_i),
    .speed_i            (speed_i),
    .accepted_o         (accepted_o),
    .key_count_o        (key_count_o),
    .total_entries_o    (total_entries_o),
    .valid_samples_o    (valid_samples_o),
    .excluded_samples_o (excluded_samples_o),
    .speed_total_o      (speed_total_o)
  );

  `HKC_ASSERT_IMP(a_commit_free, ctl_cmd.commit, !(out_valid_o && out_stall_i), "commit full")
  `HKC_ASSERT(a_hit_done_excl, !(dp_sts.hit && dp_sts.done), "hit and done together")
  `HKC_ASSERT_IMP(a_reject_zero, out_valid_o && !accepted_o, key_count_o == '0, "reject count")
  `HKC_ASSERT_IMP(a_fill_bound, out_valid_o, 32'(total_entries_o) <= MAX_ENTRIES, "overfilled")

endmodule

// ===== dv/hourly_key_counter_table_tb.sv =====
// Self-checking testbench for hourly_key_counter_table: random and directed record and clear
// words, random idling on both channels, a scoreboard class that predicts every result.
// Depends on hkc_pkg and the hourly_key_counter_table RTL.
module hourly_key_counter_table_tb import hkc_pkg::*;;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 300;
  localparam bit [CNT_W-1:0] CNT_MAX = '1;
  localparam bit [SUM_W-1:0] SUM_MAX = '1;

  typedef enum bit {
    CMD_RECORD = 1'b0,
    CMD_CLEAR  = 1'b1
  } log_cmd_t;

  typedef struct packed {
    log_cmd_t           cmd;
    bit [2:0]           module_id;
    bit [13:0]          year;
    bit [3:0]           month;
    bit [4:0]           day;
    bit [4:0]           hour;
    bit                 has_speed;
    bit                 speed_in_range;
    bit [SPEED_W-1:0]   speed;
  } log_word_t;

  typedef struct packed {
    logic               accepted;
    logic [CNT_W-1:0]   key_count;
    logic [8:0]         total_entries;
    logic [CNT_W-1:0]   valid_samples;
    logic [CNT_W-1:0]   excluded_samples;
    logic [SUM_W-1:0]   speed_total;
  } tally_t;

  class hour_tally_board;
    bit               slot_live[MAX_ENTRIES];
    bit [KEY_W-1:0]   slot_key[MAX_ENTRIES];
    bit [CNT_W-1:0]   slot_hits[MAX_ENTRIES];
    int               keys_stored;
    bit [CNT_W-1:0]   in_range_cnt;
    bit [CNT_W-1:0]   out_range_cnt;
    bit [SUM_W-1:0]   speed_acc;
    tally_t           awaited_tallies[$];
    int               errors;

    function void wipe();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      keys_stored   = 0;
      in_range_cnt  = '0;
      out_range_cnt = '0;
      speed_acc     = '0;
    endfunction

    function void push_tally(bit acc, bit [CNT_W-1:0] cnt);
      tally_t t;
      t.accepted         = acc;
      t.key_count        = cnt;
      t.total_entries    = 9'(keys_stored);
      t.valid_samples    = in_range_cnt;
      t.excluded_samples = out_range_cnt;
      t.speed_total      = speed_acc;
      awaited_tallies.push_back(t);
    endfunction

    function void note_word(log_word_t w);
      bit [KEY_W-1:0] key;
      bit [SUM_W-1:0] s;
      bit [CNT_W-1:0] cnt;
      int hit;
      int free_slot;
      hit = -1;
      free_slot = -1;
      if (w.cmd == CMD_CLEAR) begin
        wipe();
        push_tally(1'b1, '0);
        return;
      end
      if (int'(w.module_id) >= MODULE_COUNT) begin
        push_tally(1'b0, '0);
        return;
      end
      key = {w.module_id, w.year, w.month, w.day, w.hour};
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_live[i]) begin
          if (hit < 0 && slot_key[i] == key) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0) begin
        if (slot_hits[hit] != CNT_MAX) slot_hits[hit]++;
        cnt = slot_hits[hit];
      end else begin
        // full table: new key dropped, speed ignored
        if (keys_stored >= MAX_ENTRIES || free_slot < 0) begin
          push_tally(1'b0, '0);
          return;
        end
        slot_live[free_slot] = 1'b1;
        slot_key[free_slot]  = key;
        slot_hits[free_slot] = 1;
        keys_stored++;
        cnt = 1;
      end
      if (w.has_speed) begin
        if (w.speed_in_range) begin
          s = SUM_W'(w.speed);
          speed_acc = (speed_acc > SUM_MAX - s) ? SUM_MAX : speed_acc + s;
          if (in_range_cnt != CNT_MAX) in_range_cnt++;
        end else if (out_range_cnt != CNT_MAX) begin
          out_range_cnt++;
        end
      end
      push_tally(1'b1, cnt);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 10) $display("mismatch %s: expected %0h, actual %0h", what, want, got);
    endfunction

    function void check_word(tally_t got);
      tally_t want;
      if (awaited_tallies.size() == 0) begin
        flag("unexpected word", '0, 64'(got.key_count));
        return;
      end
      want = awaited_tallies.pop_front();
      if (want.accepted !== got.accepted)
        flag("accepted", 64'(want.accepted), 64'(got.accepted));
      if (want.key_count !== got.key_count)
        flag("key_count", 64'(want.key_count), 64'(got.key_count));
      if (want.total_entries !== got.total_entries)
        flag("total_entries", 64'(want.total_entries), 64'(got.total_entries));
      if (want.valid_samples !== got.valid_samples)
        flag("valid_samples", 64'(want.valid_samples), 64'(got.valid_samples));
      if (want.excluded_samples !== got.excluded_samples)
        flag("excluded_samples", 64'(want.excluded_samples), 64'(got.excluded_samples));
      if (want.speed_total !== got.speed_total)
        flag("speed_total", 64'(want.speed_total), 64'(got.speed_total));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               cmd_i = 1'b0;
  logic [2:0]         module_id_i = '0;
  logic [13:0]        year_i = '0;
  logic [3:0]         month_i = '0;
  logic [4:0]         day_i = '0;
  logic [4:0]         hour_i = '0;
  logic               has_speed_i = 1'b0;
  logic               speed_in_range_i = 1'b0;
  logic [SPEED_W-1:0] speed_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               accepted_o;
  logic [CNT_W-1:0]   key_count_o;
  logic [8:0]         total_entries_o;
  logic [CNT_W-1:0]   valid_samples_o;
  logic [CNT_W-1:0]   excluded_samples_o;
  logic [SUM_W-1:0]   speed_total_o;

  hour_tally_board sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int cycles = 0;
  log_word_t key_pool[$];
  log_word_t stored_keys[$];

  hourly_key_counter_table dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .module_id_i        (module_id_i),
    .year_i             (year_i),
    .month_i            (month_i),
    .day_i              (day_i),
    .hour_i             (hour_i),
    .has_speed_i        (has_speed_i),
    .speed_in_range_i   (speed_in_range_i),
    .speed_i            (speed_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .accepted_o         (accepted_o),
    .key_count_o        (key_count_o),
    .total_entries_o    (total_entries_o),
    .valid_samples_o    (valid_samples_o),
    .excluded_samples_o (excluded_samples_o),
    .speed_total_o      (speed_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: long hold-off when requested, else random stall
  always @(negedge clk_i) begin
    if (hold_left == 0 && hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word({accepted_o, key_count_o, total_entries_o, valid_samples_o,
                     excluded_samples_o, speed_total_o});
  end

  function automatic log_word_t rec(bit [2:0] m, bit [13:0] y, bit [3:0] mo, bit [4:0] d,
                                    bit [4:0] h, bit hs, bit rng, bit [SPEED_W-1:0] spd);
    log_word_t w;
    w = '0;
    w.cmd = CMD_RECORD;
    w.module_id = m;
    w.year = y;
    w.month = mo;
    w.day = d;
    w.hour = h;
    w.has_speed = hs;
    w.speed_in_range = rng;
    w.speed = spd;
    return w;
  endfunction

  function automatic log_word_t clear_word();
    log_word_t w;
    w = '0;
    w.cmd = CMD_CLEAR;
    w.year = 14'($urandom());
    w.speed = SPEED_W'($urandom());
    return w;
  endfunction

  function automatic log_word_t random_key();
    log_word_t w;
    w = '0;
    w.cmd = CMD_RECORD;
    w.module_id = 3'($urandom_range(0, MODULE_COUNT - 1));
    if ($urandom_range(0, 7) == 0) begin
      w.year  = 14'($urandom());
      w.month = 4'($urandom());
      w.day   = 5'($urandom());
      w.hour  = 5'($urandom());
    end else begin
      w.year  = 14'($urandom_range(0, 9999));
      w.month = 4'($urandom_range(1, 12));
      w.day   = 5'($urandom_range(1, 31));
      w.hour  = 5'($urandom_range(0, 23));
    end
    return w;
  endfunction

  function automatic log_word_t with_speed(log_word_t w);
    w.has_speed = ($urandom_range(0, 3) != 0);
    w.speed_in_range = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 9))
      0: w.speed = '0;
      1: w.speed = '1;
      default: w.speed = SPEED_W'($urandom());
    endcase
    return w;
  endfunction

  task automatic send_word(input log_word_t w);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= w.cmd;
    module_id_i      <= w.module_id;
    year_i           <= w.year;
    month_i          <= w.month;
    day_i            <= w.day;
    hour_i           <= w.hour;
    has_speed_i      <= w.has_speed;
    speed_in_range_i <= w.speed_in_range;
    speed_i          <= w.speed;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.awaited_tallies.size() != 0) @(posedge clk_i);
  endtask

  // small key pool per phase so most words hit stored keys
  task automatic run_phase(int n, int idle, int stall, int hold);
    log_word_t w;
    int pool_size;
    idle_pct = idle;
    stall_pct = stall;
    key_pool.delete();
    pool_size = $urandom_range(1, 40);
    repeat (pool_size) key_pool.push_back(random_key());
    hold_request = hold;
    repeat (n) begin
      if ($urandom_range(0, 99) < 2) begin
        w = clear_word();
      end else if ($urandom_range(0, 99) < 85) begin
        w = with_speed(key_pool[$urandom_range(0, key_pool.size() - 1)]);
      end else begin
        w = with_speed(random_key());
      end
      send_word(w);
    end
    drain();
  endtask

  // fill every slot, then mix rejected new keys with hits deep in the table
  task automatic fill_phase();
    log_word_t w;
    idle_pct = 0;
    stall_pct = 30;
    stored_keys.delete();
    send_word(clear_word());
    while (sb.keys_stored < MAX_ENTRIES) begin
      w = with_speed(random_key());
      stored_keys.push_back(w);
      send_word(w);
    end
    idle_pct = 30;
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) w = with_speed(random_key());
      else w = with_speed(stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
      send_word(w);
    end
    send_word(with_speed(stored_keys[stored_keys.size() - 1]));
    drain();
  endtask

  initial begin
    sb = new();
    sb.wipe();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(clear_word());
    send_word(rec(3'd0, 14'd0, 4'd1, 5'd1, 5'd0, 1'b0, 1'b0, '0));
    send_word(rec(3'd0, 14'd0, 4'd1, 5'd1, 5'd0, 1'b1, 1'b1, '1));
    send_word(rec(3'd0, 14'd0, 4'd1, 5'd1, 5'd0, 1'b1, 1'b0, '1));
    send_word(rec(3'd0, 14'd0, 4'd1, 5'd1, 5'd0, 1'b0, 1'b1, '1));
    send_word(rec(3'd7, 14'd9999, 4'd12, 5'd31, 5'd23, 1'b1, 1'b1, '0));
    send_word(rec(3'd7, 14'h3FFF, 4'hF, 5'd31, 5'd31, 1'b1, 1'b1, '1));
    send_word(rec(3'd0, 14'd0, 4'd0, 5'd0, 5'd0, 1'b1, 1'b1, 24'd1));
    send_word(rec(3'd7, 14'h3FFF, 4'hF, 5'd31, 5'd31, 1'b1, 1'b0, 24'h5A5A5A));
    send_word(rec(3'd7, 14'd9999, 4'd12, 5'd31, 5'd22, 1'b1, 1'b1, 24'hA5A5A5));
    send_word(clear_word());
    send_word(rec(3'd0, 14'd0, 4'd1, 5'd1, 5'd0, 1'b1, 1'b1, 24'h000100));
    send_word(rec(3'd7, 14'h3FFF, 4'hF, 5'd31, 5'd31, 1'b1, 1'b1, '1));
    drain();

    run_phase(110, 0, 0, 200);
    run_phase(110, 69, 0, 0);
    fill_phase();
    run_phase(110, 0, 69, 0);
    run_phase(110, 30, 30, 0);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited_tallies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
